// ===== hdl/dad_pkg.sv =====
`timescale 1ns / 1ps

package dad_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  // Day of year after the count is added: up to 366 + 511.
  localparam int ORD_W = 10;

  localparam logic [COUNT_W-1:0] MAX_ADD_RESET = 9'd300;
  localparam logic [YEAR_W-1:0]  YEAR_LIMIT    = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
  localparam logic [ORD_W-1:0]   DAYS_COMMON   = 10'd365;
  localparam logic [ORD_W-1:0]   DAYS_LEAP     = 10'd366;

  // Divisibility by 25: y * inverse(25) mod 2^14 lands at or below
  // floor((2^14 - 1) / 25) exactly when 25 divides y.
  localparam logic [YEAR_W-1:0] INV25      = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVER_MAX = 2'd1,
    ST_BAD_DATE = 2'd2
  } dad_status_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [COUNT_W-1:0] add;
  } dad_req_t;

  typedef struct packed {
    dad_status_t        status;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } dad_res_t;

  // Divisible by 4 and not by 100, or divisible by 400.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] p;
    logic div25;
    p     = YEAR_W'(y * INV25);
    div25 = (p <= DIV25_LIMIT);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  // Days before the first of month m in a common year.
  function automatic logic [ORD_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [ORD_W-1:0] r;
    case (m)
      4'd1:    r = 10'd0;
      4'd2:    r = 10'd31;
      4'd3:    r = 10'd59;
      4'd4:    r = 10'd90;
      4'd5:    r = 10'd120;
      4'd6:    r = 10'd151;
      4'd7:    r = 10'd181;
      4'd8:    r = 10'd212;
      4'd9:    r = 10'd243;
      4'd10:   r = 10'd273;
      4'd11:   r = 10'd304;
      4'd12:   r = 10'd334;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W:0] month_len(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    logic [DAY_W:0] r;
    case (m)
      4'd2:                      r = leap ? 6'd29 : 6'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 6'd30;
      default:                   r = 6'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/dad_calc.sv =====
`timescale 1ns / 1ps

module dad_calc (
  input  dad_pkg::dad_req_t             req,
  input  logic [dad_pkg::COUNT_W-1:0]   max_add,
  output dad_pkg::dad_res_t             res
);
  import dad_pkg::*;

  logic [YEAR_W-1:0]  year1, year2, year_f;
  logic               leap0, leap1, leap2, leap_f;
  logic               bad_date;
  logic [ORD_W-1:0]   ord0, ord1, ord2, len0, len1, end_k, day_w;
  logic               roll1, roll2;
  logic [10:0]        past;
  logic [MONTH_W-1:0] mo;

  always_comb begin
    year1 = req.year + 14'd1;
    year2 = req.year + 14'd2;
    leap0 = is_leap(req.year);
    leap1 = is_leap(year1);
    leap2 = is_leap(year2);

    bad_date = (req.month == 4'd0) || (req.month > MONTH_DEC) ||
               (req.year == 14'd0) || (req.year > YEAR_LIMIT) ||
               (req.day == 5'd0) ||
               ({1'b0, req.day} > month_len(req.month, leap0));

    // Day of year, one based, plus the count.
    ord0 = month_start(req.month) + ORD_W'(req.day) + ORD_W'(req.add) +
           ORD_W'(leap0 && (req.month > MONTH_FEB));

    // Up to two year ends can be passed.
    len0  = leap0 ? DAYS_LEAP : DAYS_COMMON;
    roll1 = (ord0 > len0);
    ord1  = roll1 ? ord0 - len0 : ord0;
    len1  = leap1 ? DAYS_LEAP : DAYS_COMMON;
    roll2 = roll1 && (ord1 > len1);
    ord2  = roll2 ? ord1 - len1 : ord1;

    year_f = roll2 ? year2 : (roll1 ? year1 : req.year);
    leap_f = roll2 ? leap2 : (roll1 ? leap1 : leap0);

    // Month is one plus the number of month ends already passed.
    for (int k = 1; k < 12; k++) begin
      end_k = month_start(MONTH_W'(k + 1)) + ORD_W'(leap_f && (k >= 2));
      past[k-1] = (ord2 > end_k);
    end
    mo    = MONTH_W'($countones(past)) + 4'd1;
    day_w = ord2 - month_start(mo) - ORD_W'(leap_f && (mo > MONTH_FEB));

    res = '0;
    if (req.add > max_add) begin
      res.status = ST_OVER_MAX;
    end else if (bad_date) begin
      res.status = ST_BAD_DATE;
    end else begin
      res.status = ST_OK;
      res.day    = day_w[DAY_W-1:0];
      res.month  = mo;
      res.year   = year_f;
    end
  end

endmodule

// ===== hdl/date_add_days_top.sv =====
`timescale 1ns / 1ps
// Gregorian date plus a day count, with a status for bad counts and dates.
// The accepted input word is held in the input stage, and its result word is
// registered in the output stage when that stage can take it.
// Throughput: one word per cycle while out_ready stays high.
// Reset (rst, synchronous, active high) empties both stages and sets max_add
// to 300.

module date_add_days_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dad_pkg::COUNT_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dad_pkg::DAY_W-1:0]      start_day,
  input  logic [dad_pkg::MONTH_W-1:0]    start_month,
  input  logic [dad_pkg::YEAR_W-1:0]     start_year,
  input  logic [dad_pkg::COUNT_W-1:0]    days_to_add,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dad_pkg::STATUS_W-1:0]   status,
  output logic [dad_pkg::DAY_W-1:0]      new_day,
  output logic [dad_pkg::MONTH_W-1:0]    new_month,
  output logic [dad_pkg::YEAR_W-1:0]     new_year
);
  import dad_pkg::*;

  // Configured limit on the day count.
  logic [COUNT_W-1:0] max_add;

  // Input stage: the accepted word waits here while the date logic works on it.
  logic     req_valid;
  dad_req_t req;

  // Output stage: the finished result word, held until the consumer takes it.
  logic     res_valid;
  dad_res_t res;
  dad_res_t res_next;

  logic res_advance;
  logic req_advance;

  // The output register frees when empty or drained this cycle, and the input
  // register frees when it can hand its word on. This keeps one word per cycle
  // moving while out_ready is high, even with a finished result waiting downstream.
  assign res_advance = !res_valid || out_ready;
  assign req_advance = !req_valid || res_advance;
  assign in_ready    = req_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_add <= MAX_ADD_RESET;
    end else if (cfg_we) begin
      max_add <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_advance) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_advance && in_valid) begin
      req.day   <= start_day;
      req.month <= start_month;
      req.year  <= start_year;
      req.add   <= days_to_add;
    end
  end

  // Leap tests, day-of-year sum, year roll and month search all fit between
  // the two registers.
  dad_calc u_calc (
    .req     (req),
    .max_add (max_add),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_advance) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_advance && req_valid) begin
      res <= res_next;
    end
  end

  assign out_valid = res_valid;
  assign status    = res.status;
  assign new_day   = res.day;
  assign new_month = res.month;
  assign new_year  = res.year;

endmodule
